// ===== design/bwl_pkg.sv =====
package bwl_pkg;

	localparam int RNG_W  = 6;
	localparam int COEF_W = 32;
	localparam int NTAP   = 5;

	localparam logic [1:0] REG_LOWEST   = 2'd0;
	localparam logic [1:0] REG_TWO_PT   = 2'd1;
	localparam logic [1:0] REG_THREE_PT = 2'd2;

	localparam logic [20:0] LOWEST_RST   = 21'd748980;
	localparam logic [23:0] TWO_PT_RST   = 24'd19661;
	localparam logic [23:0] THREE_PT_RST = 24'd10486;

	localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

	typedef enum logic [1:0] {
		ORD_LIN,
		ORD_3PT,
		ORD_5PT
	} order_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [NTAP-1:0] coef_vec_t;

	typedef struct packed {
		logic [RNG_W-1:0] lo;
		logic [RNG_W-1:0] hi;
		logic [15:0]      w;
	} pitch_t;

	// piecewise log2 breakpoints, round(65536*log2(1+k/8))
	function automatic logic [16:0] log_seg(input logic [3:0] k);
		logic [16:0] v;
		unique case (k)
			4'd0: v = 17'd0;
			4'd1: v = 17'd11136;
			4'd2: v = 17'd21098;
			4'd3: v = 17'd30109;
			4'd4: v = 17'd38336;
			4'd5: v = 17'd45904;
			4'd6: v = 17'd52911;
			4'd7: v = 17'd59434;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

	// floor(n/3) by reciprocal, exact for any 32 bit n
	function automatic logic [31:0] div3(input logic [31:0] n);
		logic [65:0] prod;
		prod = 66'(n) * 66'd2863311531;
		return prod[64:33];
	endfunction

endpackage

// ===== design/bwl_ifs.sv =====
interface bwl_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [5:0]         range_select;
	logic [11:0]        table_addr;
	logic signed [15:0] write_sample;
	logic signed [25:0] frequency;
	logic [27:0]        read_position;
	logic signed [24:0] phase_step;

	modport source(output valid, cmd, range_select, table_addr, write_sample, frequency,
		read_position, phase_step, input ready);
	modport sink(input valid, cmd, range_select, table_addr, write_sample, frequency,
		read_position, phase_step, output ready);
endinterface

interface bwl_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface

// ===== design/bwl_pitch.sv =====
module bwl_pitch import bwl_pkg::*; #(
	parameter int NUM_RANGES = 36
) (
	input  logic        clk,
	input  logic        adv,
	input  logic [25:0] a_s1,
	input  logic [20:0] lowest,
	output pitch_t      pitch_s6
);

	localparam logic signed [24:0] PMAX = 25'(NUM_RANGES - 1) <<< 16;

	logic [4:0]         e_s2, e_s3, e_s4;
	logic [25:0]        a_s2;
	logic               zero_s2, zero_s3, zero_s4, zero_s5;
	logic [2:0]         k_s3;
	logic [12:0]        r_s3;
	logic [13:0]        d_s4;
	logic [16:0]        seg_s4;
	logic signed [24:0] praw_s5;

	logic [4:0]         e_c;
	logic [25:0]        norm;
	logic [16:0]        seg_a, seg_b, seg_d;
	logic [26:0]        dprod;
	logic [21:0]        lsum;
	logic signed [24:0] ldiff, praw;
	logic signed [24:0] pc;
	logic [RNG_W-1:0]   lo_c;

	// leading one
	always_comb begin
		e_c = '0;
		for (int i = 0; i < 26; i++) begin
			if (a_s1[i]) e_c = 5'(i);
		end
	end

	assign norm  = a_s2 << (5'd25 - e_s2);
	assign seg_a = log_seg({1'b0, k_s3});
	assign seg_b = log_seg(4'({1'b0, k_s3}) + 4'd1);
	assign seg_d = seg_b - seg_a;
	assign dprod = 27'(seg_d[13:0]) * 27'(r_s3);
	assign lsum  = 22'({e_s4, 16'h0000}) + 22'(seg_s4) + 22'(d_s4);
	assign ldiff = $signed({3'b000, lsum}) - $signed({4'b0000, lowest});
	assign praw  = 25'sd65536 + ldiff + (ldiff <<< 1);

	always_comb begin
		priority if (zero_s5 || praw_s5 < 25'sd0) begin
			pc = '0;
		end else if (praw_s5 > PMAX) begin
			pc = PMAX;
		end else begin
			pc = praw_s5;
		end
	end

	assign lo_c = pc[16 +: RNG_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s2    <= e_c;
			a_s2    <= a_s1;
			zero_s2 <= (a_s1 == '0);
			k_s3    <= norm[24:22];
			r_s3    <= norm[21:9];
			e_s3    <= e_s2;
			zero_s3 <= zero_s2;
			d_s4    <= dprod[26:13];
			seg_s4  <= seg_a;
			e_s4    <= e_s3;
			zero_s4 <= zero_s3;
			praw_s5 <= praw;
			zero_s5 <= zero_s4;
			pitch_s6.lo <= lo_c;
			pitch_s6.hi <= (32'(lo_c) < NUM_RANGES - 1) ? lo_c + 1'b1 : lo_c;
			pitch_s6.w  <= pc[15:0];
		end
	end

endmodule

// ===== design/bwl_coef.sv =====
module bwl_coef import bwl_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [15:0]      f_s1,
	input  order_t           ord_s1,
	output coef_vec_t        coef_s6,
	output logic [NTAP-1:0]  mask_s6
);

	logic [15:0] f_s2, f_s3, f_s4;
	order_t      ord_s2, ord_s3, ord_s4, ord_s5;
	logic [31:0] ff_s2;
	logic [32:0] tmn_s2;
	logic [33:0] um_s2;
	coef_vec_t   base_s3, base_s4, base_s5;
	logic [28:0] tn_s3, pn_s3;
	logic [29:0] un_s3;
	logic [30:0] qn_s3;
	logic [28:0] xpn_s4;
	logic [31:0] n1_s4, n3_s4, n1_s5, n3_s5;
	logic [29:0] c2_s4, c2_s5;
	logic [31:0] n0_s5, n4_s5;

	logic [27:0] x2;
	logic [28:0] x;
	coef_vec_t   base_c;
	logic [44:0] xpp;
	logic [59:0] tq, pq;
	logic [60:0] uq;
	logic [46:0] m0, m4;

	assign x2 = ff_s2[31:4];
	assign x  = {1'b0, f_s2, 12'h000};

	always_comb begin
		base_c = '0;
		unique case (ord_s2)
			ORD_LIN: begin
				base_c[2] = coef_t'(ONE_Q28 - x);
				base_c[3] = coef_t'(x);
			end
			ORD_3PT: begin
				base_c[1] = -coef_t'(tmn_s2 >> 5);
				base_c[2] = coef_t'(ONE_Q28 - 29'(x2));
				base_c[3] = coef_t'(um_s2 >> 5);
			end
			default: base_c = '0;
		endcase
	end

	assign xpp = 45'(f_s3) * 45'(pn_s3);
	assign tq  = 60'(tn_s3) * 60'(qn_s3);
	assign uq  = 61'(un_s3) * 61'(qn_s3);
	assign pq  = 60'(pn_s3) * 60'(qn_s3);
	assign m0  = 47'(xpn_s4) * 47'(18'h20000 - 18'(f_s4));
	assign m4  = 47'(xpn_s4) * 47'(18'h20000 + 18'(f_s4));

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2    <= f_s1;
			ord_s2  <= ord_s1;
			ff_s2   <= 32'(f_s1) * 32'(f_s1);
			tmn_s2  <= 33'(f_s1) * (33'h10000 - 33'(f_s1));
			um_s2   <= 34'(f_s1) * (34'h10000 + 34'(f_s1));

			f_s3    <= f_s2;
			ord_s3  <= ord_s2;
			base_s3 <= base_c;
			tn_s3   <= 29'(tmn_s2 >> 4);
			un_s3   <= 30'(um_s2 >> 4);
			pn_s3   <= ONE_Q28 - 29'(x2);
			qn_s3   <= 31'h4000_0000 - 31'(x2);

			f_s4    <= f_s3;
			ord_s4  <= ord_s3;
			base_s4 <= base_s3;
			xpn_s4  <= xpp[44:16];
			n1_s4   <= 32'(tq >> 29);
			n3_s4   <= 32'(uq >> 29);
			c2_s4   <= 30'(pq >> 30);

			ord_s5  <= ord_s4;
			base_s5 <= base_s4;
			n0_s5   <= 32'(m0 >> 19);
			n4_s5   <= 32'(m4 >> 19);
			n1_s5   <= n1_s4;
			n3_s5   <= n3_s4;
			c2_s5   <= c2_s4;

			unique case (ord_s5)
				ORD_LIN: begin
					coef_s6 <= base_s5;
					mask_s6 <= 5'b01100;
				end
				ORD_3PT: begin
					coef_s6 <= base_s5;
					mask_s6 <= 5'b01110;
				end
				default: begin
					coef_s6[0] <= coef_t'(div3(n0_s5));
					coef_s6[1] <= -coef_t'(div3(n1_s5));
					coef_s6[2] <= coef_t'(c2_s5);
					coef_s6[3] <= coef_t'(div3(n3_s5));
					coef_s6[4] <= -coef_t'(div3(n4_s5));
					mask_s6    <= 5'b11111;
				end
			endcase
		end
	end

endmodule

// ===== design/bwl_tap_read.sv =====
module bwl_tap_read import bwl_pkg::*; #(
	parameter int DEPTH = 147456,
	parameter int AW    = 18
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [15:0]               wdata,
	input  logic [NTAP-1:0][AW-1:0]   raddr_lo,
	input  logic [NTAP-1:0][AW-1:0]   raddr_hi,
	output wire  [NTAP-1:0][15:0]     word_lo_s9,
	output wire  [NTAP-1:0][15:0]     word_hi_s9
);

	// one copy of the store per tap, each read for both ranges
	for (genvar j = 0; j < NTAP; j++) begin : g_copy
		logic [15:0] mem [DEPTH];
		logic [15:0] rd_lo_s9, rd_hi_s9;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (we) mem[waddr] <= wdata;
				rd_lo_s9 <= mem[raddr_lo[j]];
				rd_hi_s9 <= mem[raddr_hi[j]];
			end
		end

		assign word_lo_s9[j] = rd_lo_s9;
		assign word_hi_s9[j] = rd_hi_s9;
	end

endmodule

// ===== design/bandlimited_wavetable_lookup_core.sv =====
// Band-limited wavetable lookup.
// in_chan carries items: cmd low writes one table word into the range given by
// range_select at table_addr, cmd high looks up one sample from frequency,
// read_position and phase_step. out_chan returns one sample per lookup and
// nothing for a write. Both channels transfer when valid and ready are high.
// The configuration port writes one register per cycle with cfg_wen; it must be
// written only while no item is in flight; the block itself does not enforce this.
// The datapath is a 13 stage pipeline that takes one item per clock unless
// out_chan stalls, and the last stage drives out_chan directly. Writes
// reach the table store in order with lookups, so a lookup sees every write
// that came before it. Ten table words per lookup come from five copies of the
// store, each read at two addresses a cycle.
// Reset clears the valid bits and loads the configuration defaults; the table
// store is not cleared and must be written before it is read.
// When out_chan is stalled with a result waiting, the whole pipeline holds and
// in_chan.ready goes low; nothing is lost or repeated.
module bandlimited_wavetable_lookup_core import bwl_pkg::*; #(
	parameter int TABLE_SIZE = 4096,
	parameter int NUM_RANGES = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	bwl_in_if.sink      in_chan,
	bwl_out_if.source   out_chan
);

	localparam int DEPTH = NUM_RANGES * TABLE_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(TABLE_SIZE);
	localparam int RECIP = (1 << 24) / TABLE_SIZE + 1;

	typedef struct packed {
		logic          look;
		logic          wok;
		logic [AW-1:0] waddr;
		logic [15:0]   wdata;
	} side_t;

	logic [20:0] lowest_q;
	logic [23:0] two_thr_q, three_thr_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic out_valid_q;
	logic signed [15:0] sample_q;

	logic               look_s1;
	logic [RNG_W-1:0]   rsel_s1;
	logic [11:0]        taddr_s1;
	logic [15:0]        wdat_s1;
	logic [25:0]        a_s1;
	logic [15:0]        f_s1;
	logic [11:0]        ip_s1, ip_s2;
	order_t             ord_s1;
	logic [5:0]         iq_s2;
	logic [IW-1:0]      idx_s3, idx_s4, idx_s5, idx_s6;
	side_t              side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	pitch_t             pitch_s6;
	coef_vec_t          coef_s6, coef_s7, coef_s8, coef_s9;
	logic [NTAP-1:0]    mask_s6, mask_s7, mask_s8, mask_s9;
	logic [15:0]        w_s7, w_s8, w_s9, w_s10, w_s11;
	logic [AW-1:0]      blo_s7, bhi_s7;
	logic [IW-1:0]      pos_s7 [NTAP];
	logic               look_s8, look_s9, look_s10, look_s11, look_s12;
	logic               wen_s8;
	logic [AW-1:0]      waddr_s8;
	logic [15:0]        wdata_s8;
	logic [NTAP-1:0][AW-1:0] alo_s8, ahi_s8;
	logic [NTAP-1:0][15:0]   word_lo_s9, word_hi_s9;
	logic signed [47:0] plo_s10 [NTAP];
	logic signed [47:0] phi_s10 [NTAP];
	logic signed [39:0] vlo_s11, vhi_s11;
	logic signed [57:0] blo_s12, bhi_s12;

	logic [25:0]        a_c;
	order_t             ord_c;
	logic [29:0]        iq_prod;
	logic [31:0]        idx_full;
	logic [IW-1:0]      pos_c [NTAP];
	logic signed [50:0] acc_lo, acc_hi;
	logic signed [59:0] vsum;
	logic signed [27:0] res;
	logic signed [15:0] sat;

	assign adv           = !out_valid_q || out_chan.ready;
	assign in_chan.ready = adv;
	assign out_chan.valid  = out_valid_q;
	assign out_chan.sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q    <= LOWEST_RST;
			two_thr_q   <= TWO_PT_RST;
			three_thr_q <= THREE_PT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LOWEST:   lowest_q    <= cfg_data[20:0];
				REG_TWO_PT:   two_thr_q   <= cfg_data;
				REG_THREE_PT: three_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// magnitude of the frequency and interpolation order
	assign a_c = in_chan.frequency[25] ? (~in_chan.frequency + 26'd1) : in_chan.frequency;

	always_comb begin
		priority if ($signed({in_chan.phase_step[24], in_chan.phase_step}) >=
				$signed({2'b00, two_thr_q})) begin
			ord_c = ORD_LIN;
		end else if ($signed({in_chan.phase_step[24], in_chan.phase_step}) >=
				$signed({2'b00, three_thr_q})) begin
			ord_c = ORD_3PT;
		end else begin
			ord_c = ORD_5PT;
		end
	end

	assign iq_prod  = 30'(ip_s1) * 30'(RECIP);
	assign idx_full = 32'(ip_s2) - 32'(iq_s2) * 32'(TABLE_SIZE);

	// wrapped tap positions, offsets -2..+2
	always_comb begin
		for (int j = 0; j < NTAP; j++) begin
			int tp;
			tp = int'(idx_s6) + j - 2;
			if (tp < 0) tp = tp + TABLE_SIZE;
			else if (tp >= TABLE_SIZE) tp = tp - TABLE_SIZE;
			pos_c[j] = IW'(tp);
		end
	end

	always_comb begin
		acc_lo = '0;
		acc_hi = '0;
		for (int j = 0; j < NTAP; j++) begin
			acc_lo = acc_lo + 51'(plo_s10[j]);
			acc_hi = acc_hi + 51'(phi_s10[j]);
		end
	end

	assign vsum = 60'(blo_s12) + 60'(bhi_s12) + (60'sd1 <<< 31);
	assign res  = 28'(vsum >>> 32);

	always_comb begin
		priority if (res > 28'sd32767) begin
			sat = 16'sh7fff;
		end else if (res < -28'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = res[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_chan.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			out_valid_q <= v_s12 && look_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			look_s1  <= in_chan.cmd;
			rsel_s1  <= in_chan.range_select;
			taddr_s1 <= in_chan.table_addr;
			wdat_s1  <= in_chan.write_sample;
			a_s1     <= a_c;
			f_s1     <= in_chan.read_position[15:0];
			ip_s1    <= in_chan.read_position[27:16];
			ord_s1   <= ord_c;

			ip_s2         <= ip_s1;
			iq_s2         <= iq_prod[29:24];
			side_s2.look  <= look_s1;
			side_s2.wok   <= (32'(rsel_s1) < NUM_RANGES) && (32'(taddr_s1) < TABLE_SIZE);
			side_s2.waddr <= AW'(32'(rsel_s1) * 32'(TABLE_SIZE) + 32'(taddr_s1));
			side_s2.wdata <= wdat_s1;

			idx_s3  <= idx_full[IW-1:0];
			side_s3 <= side_s2;
			idx_s4  <= idx_s3;
			side_s4 <= side_s3;
			idx_s5  <= idx_s4;
			side_s5 <= side_s4;
			idx_s6  <= idx_s5;
			side_s6 <= side_s5;

			blo_s7  <= AW'(32'(pitch_s6.lo) * 32'(TABLE_SIZE));
			bhi_s7  <= AW'(32'(pitch_s6.hi) * 32'(TABLE_SIZE));
			pos_s7  <= pos_c;
			coef_s7 <= coef_s6;
			mask_s7 <= mask_s6;
			w_s7    <= pitch_s6.w;
			side_s7 <= side_s6;

			for (int j = 0; j < NTAP; j++) begin
				alo_s8[j] <= blo_s7 + AW'(pos_s7[j]);
				ahi_s8[j] <= bhi_s7 + AW'(pos_s7[j]);
			end
			coef_s8  <= coef_s7;
			mask_s8  <= mask_s7;
			w_s8     <= w_s7;
			look_s8  <= side_s7.look;
			wen_s8   <= v_s7 && !side_s7.look && side_s7.wok;
			waddr_s8 <= side_s7.waddr;
			wdata_s8 <= side_s7.wdata;

			coef_s9 <= coef_s8;
			mask_s9 <= mask_s8;
			w_s9    <= w_s8;
			look_s9 <= look_s8;

			for (int j = 0; j < NTAP; j++) begin
				plo_s10[j] <= mask_s9[j] ?
					$signed(word_lo_s9[j]) * $signed(coef_s9[j]) : 48'sd0;
				phi_s10[j] <= mask_s9[j] ?
					$signed(word_hi_s9[j]) * $signed(coef_s9[j]) : 48'sd0;
			end
			w_s10    <= w_s9;
			look_s10 <= look_s9;

			vlo_s11  <= 40'((acc_lo < 0) ? (acc_lo + 51'sd4095) >>> 12 : acc_lo >>> 12);
			vhi_s11  <= 40'((acc_hi < 0) ? (acc_hi + 51'sd4095) >>> 12 : acc_hi >>> 12);
			w_s11    <= w_s10;
			look_s11 <= look_s10;

			blo_s12  <= vlo_s11 * $signed({1'b0, 17'h10000 - {1'b0, w_s11}});
			bhi_s12  <= vhi_s11 * $signed({2'b00, w_s11});
			look_s12 <= look_s11;

			sample_q <= sat;
		end
	end

	bwl_pitch #(
		.NUM_RANGES(NUM_RANGES)
	) u_pitch (
		.clk     (clk),
		.adv     (adv),
		.a_s1    (a_s1),
		.lowest  (lowest_q),
		.pitch_s6(pitch_s6)
	);

	bwl_coef u_coef (
		.clk    (clk),
		.adv    (adv),
		.f_s1   (f_s1),
		.ord_s1 (ord_s1),
		.coef_s6(coef_s6),
		.mask_s6(mask_s6)
	);

	bwl_tap_read #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_tap_read (
		.clk       (clk),
		.adv       (adv),
		.we        (wen_s8),
		.waddr     (waddr_s8),
		.wdata     (wdata_s8),
		.raddr_lo  (alo_s8),
		.raddr_hi  (ahi_s8),
		.word_lo_s9(word_lo_s9),
		.word_hi_s9(word_hi_s9)
	);

endmodule
